/* rtl/core/imgc_pkg.sv */
// Shared constants, register indexes and types of the 3x3 image correlator.
// Depends on nothing; every other file of the block but imgc_ram imports it.
package imgc_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 8;
    localparam int COEF_BITS_DEF  = 8;

    localparam int SUM_W      = 20;
    localparam int ROW_W      = 16;
    localparam int FW_W       = 11;
    localparam int MASK_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_TAPS   = 9;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_TOP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_MIDDLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_BOTTOM  = 3'd4;

    // Control that travels with a window down the arithmetic pipeline.
    typedef struct packed {
        logic             valid;
        logic             emit;
        logic [ROW_W-1:0] row;
    } imgc_ctl_t;

endpackage

/* rtl/core/imgc_if.sv */
// Stream interfaces of the 3x3 image correlator: pixel input and result output.
// Depends on imgc_pkg for default widths.
interface imgc_pixel_if #(
    parameter int PIXEL_BITS = imgc_pkg::PIXEL_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface imgc_result_if #(
    parameter int COL_W = $clog2(imgc_pkg::MAX_WIDTH_DEF)
) ();
    import imgc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] weighted_sum;
    logic [ROW_W-1:0]        centre_row;
    logic [COL_W-1:0]        centre_col;

    modport source (output valid, output weighted_sum, output centre_row,
                    output centre_col, input ready);
    modport sink   (input valid, input weighted_sum, input centre_row,
                    input centre_col, output ready);
endinterface

/* rtl/core/imgc_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module imgc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/core/imgc_front.sv */
// Front end: raster counters, the two line stores (one RAM) and the 3x3 window.
// Depends on imgc_pkg and imgc_ram.
module imgc_front #(
    parameter int MAX_WIDTH  = imgc_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = imgc_pkg::PIXEL_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      adv,
    input  logic                                      accept,
    input  logic [PIXEL_BITS-1:0]                     pixel,
    input  logic [$clog2(MAX_WIDTH)-1:0]              last_col,
    input  logic [imgc_pkg::ROW_W-1:0]                last_row,
    output logic [imgc_pkg::NUM_TAPS-1:0][PIXEL_BITS-1:0] win,
    output imgc_pkg::imgc_ctl_t                       ctl,
    output logic [$clog2(MAX_WIDTH)-1:0]              col
);
    import imgc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [COL_W-1:0]      col_count_reg;
    logic [ROW_W-1:0]      row_count_reg;
    logic                  s1_valid_reg;
    logic [PIXEL_BITS-1:0] s1_pixel_reg;
    logic [COL_W-1:0]      s1_col_reg;
    logic [ROW_W-1:0]      s1_row_reg;
    logic [NUM_TAPS-1:0][PIXEL_BITS-1:0] win_reg;
    imgc_ctl_t             ctl_reg;
    logic [COL_W-1:0]      col_reg;

    logic [2*PIXEL_BITS-1:0] line_rdata;
    logic [PIXEL_BITS-1:0]   line_up;
    logic [PIXEL_BITS-1:0]   line_lo;
    logic                    s1_go;

    assign line_up = line_rdata[2*PIXEL_BITS-1:PIXEL_BITS];
    assign line_lo = line_rdata[PIXEL_BITS-1:0];
    assign s1_go   = adv && s1_valid_reg;

    // Both line stores share one RAM word: upper row in the high half.
    imgc_ram #(
        .WIDTH (2*PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_col_reg),
        .wdata ({line_lo, s1_pixel_reg}),
        .re    (accept),
        .raddr (col_count_reg),
        .rdata (line_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (accept)
        begin
            if (col_count_reg >= last_col)
            begin
                col_count_reg <= '0;
                row_count_reg <= (row_count_reg >= last_row) ? '0 : row_count_reg + 1'b1;
            end
            else
            begin
                col_count_reg <= col_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            ctl_reg      <= '0;
            win_reg      <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            ctl_reg.valid <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[k*3]   <= win_reg[k*3+1];
                    win_reg[k*3+1] <= win_reg[k*3+2];
                end
                win_reg[2]   <= line_up;
                win_reg[5]   <= line_lo;
                win_reg[8]   <= s1_pixel_reg;
                ctl_reg.emit <= (s1_row_reg >= ROW_W'(2)) && (s1_col_reg >= COL_W'(2));
                ctl_reg.row  <= s1_row_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_col_reg   <= col_count_reg;
            s1_row_reg   <= row_count_reg;
        end
        if (s1_go)
        begin
            col_reg <= s1_col_reg - 1'b1;
        end
    end

    assign win = win_reg;
    assign ctl = ctl_reg;
    assign col = col_reg;
endmodule

/* rtl/core/imgc_mac.sv */
// Arithmetic back end: nine products, three row sums, the total and the result register.
// Depends on imgc_pkg.
module imgc_mac #(
    parameter int PIXEL_BITS = imgc_pkg::PIXEL_BITS_DEF,
    parameter int COEF_BITS  = imgc_pkg::COEF_BITS_DEF,
    parameter int COL_W      = $clog2(imgc_pkg::MAX_WIDTH_DEF)
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  logic [imgc_pkg::NUM_TAPS-1:0][PIXEL_BITS-1:0] win,
    input  logic [imgc_pkg::NUM_TAPS-1:0][COEF_BITS-1:0]  coef,
    input  imgc_pkg::imgc_ctl_t                           ctl_in,
    input  logic [COL_W-1:0]                              col_in,
    output logic                                          valid,
    output logic signed [imgc_pkg::SUM_W-1:0]            weighted_sum,
    output logic [imgc_pkg::ROW_W-1:0]                    centre_row,
    output logic [COL_W-1:0]                              centre_col
);
    import imgc_pkg::*;

    localparam int PROD_W = PIXEL_BITS + COEF_BITS;
    localparam int RS_W   = PROD_W + 2;
    localparam int TOT_W  = (RS_W + 2 > SUM_W) ? RS_W + 2 : SUM_W;

    logic signed [PROD_W-1:0] prod_next [NUM_TAPS];
    logic signed [PROD_W-1:0] prod_reg  [NUM_TAPS];
    logic signed [RS_W-1:0]   rsum_next [3];
    logic signed [RS_W-1:0]   rsum_reg  [3];
    logic signed [TOT_W-1:0]  total;
    imgc_ctl_t                ctl_p_reg;
    imgc_ctl_t                ctl_r_reg;
    logic [COL_W-1:0]         col_p_reg;
    logic [COL_W-1:0]         col_r_reg;
    logic                     out_valid_reg;
    logic signed [SUM_W-1:0]  out_sum_reg;
    logic [ROW_W-1:0]         out_row_reg;
    logic [COL_W-1:0]         out_col_reg;

    // Pixels are unsigned, so each gets a zero sign bit before the signed multiply.
    always_comb
    begin
        for (int i = 0; i < NUM_TAPS; i++)
        begin
            prod_next[i] = $signed({1'b0, win[i]}) * $signed(coef[i]);
        end
        for (int k = 0; k < 3; k++)
        begin
            rsum_next[k] = RS_W'(prod_reg[k*3]) + RS_W'(prod_reg[k*3+1])
                         + RS_W'(prod_reg[k*3+2]);
        end
        total = TOT_W'(rsum_reg[0]) + TOT_W'(rsum_reg[1]) + TOT_W'(rsum_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_p_reg     <= '0;
            ctl_r_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ctl_p_reg     <= ctl_in;
            ctl_r_reg     <= ctl_p_reg;
            out_valid_reg <= ctl_r_reg.valid && ctl_r_reg.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg    <= prod_next;
            rsum_reg    <= rsum_next;
            col_p_reg   <= col_in;
            col_r_reg   <= col_p_reg;
            out_sum_reg <= total[SUM_W-1:0];
            out_row_reg <= ctl_r_reg.row;
            out_col_reg <= col_r_reg;
        end
    end

    assign valid        = out_valid_reg;
    assign weighted_sum = out_sum_reg;
    assign centre_row   = out_row_reg;
    assign centre_col   = out_col_reg;
endmodule

/* rtl/core/image_correlate_3x3.sv */
// Top level of the 3x3 image correlator: configuration registers and stall control.
// Depends on imgc_pkg, imgc_if, imgc_front, imgc_mac and imgc_ram.
//
// The block takes one 8-bit pixel per clock of an already zero-padded frame in
// raster order and, wherever a full 3x3 window exists (incoming row and column
// both at least two), delivers one transaction with the signed weighted sum of
// the window and the row and column of its centre; other pixels produce nothing.
// It sustains one pixel per cycle, and a result is presented after the edge
// that accepts the pixel completing its window: that edge also starts the
// registered read of the line store RAM, then the window shifts, and the
// product, row-sum and output stages follow. The whole pipeline moves
// together and halts only while a result sits in the output register and
// the sink is not ready, so pixels keep being accepted while the sink takes
// results. The two line stores share one RAM of MAX_WIDTH words; it needs
// no clearing after reset because every entry is written during the first
// two rows before its contents can reach a result. The user must write frame
// width, height and the three mask rows through the configuration port only
// while the block is idle; the block itself does not enforce this. A width
// below 3 counts as 3, above MAX_WIDTH as MAX_WIDTH, and a height below 3
// counts as 3. After the last pixel of a frame the next pixel starts a new
// one.
module image_correlate_3x3 #(
    parameter int MAX_WIDTH  = imgc_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = imgc_pkg::PIXEL_BITS_DEF,
    parameter int COEF_BITS  = imgc_pkg::COEF_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [imgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [imgc_pkg::CFG_DATA_W-1:0]   cfg_data,
    imgc_pixel_if.sink                        pixels,
    imgc_result_if.source                     results
);
    import imgc_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int MW    = (3*COEF_BITS > MASK_W) ? 3*COEF_BITS : MASK_W;

    // Configuration registers.
    logic [FW_W-1:0]   width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [MASK_W-1:0] mask_reg [3];

    logic [COL_W-1:0]  last_col;
    logic [ROW_W-1:0]  last_row;
    logic [MW-1:0]     mask_ext [3];
    logic [NUM_TAPS-1:0][COEF_BITS-1:0]  coef;
    logic [NUM_TAPS-1:0][PIXEL_BITS-1:0] win;
    imgc_ctl_t         ctl;
    logic [COL_W-1:0]  win_col;
    logic              out_valid;
    logic              adv;
    logic              accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= FW_W'(3);
            height_reg  <= ROW_W'(3);
            mask_reg[0] <= '0;
            mask_reg[1] <= '0;
            mask_reg[2] <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  width_reg   <= cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: height_reg  <= cfg_data[ROW_W-1:0];
                REG_MASK_TOP:     mask_reg[0] <= cfg_data[MASK_W-1:0];
                REG_MASK_MIDDLE:  mask_reg[1] <= cfg_data[MASK_W-1:0];
                REG_MASK_BOTTOM:  mask_reg[2] <= cfg_data[MASK_W-1:0];
                default:          ;
            endcase
        end
    end

    // Last column and last row index after clamping the frame size.
    always_comb
    begin
        if (width_reg < FW_W'(3))
        begin
            last_col = COL_W'(2);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(width_reg - 1'b1);
        end
        last_row = (height_reg < ROW_W'(3)) ? ROW_W'(2) : height_reg - 1'b1;
    end

    // Coefficient fields beyond the 24 register bits read as zero.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mask_ext[k] = MW'(mask_reg[k]);
            for (int l = 0; l < 3; l++)
            begin
                coef[k*3+l] = mask_ext[k][l*COEF_BITS +: COEF_BITS];
            end
        end
    end

    // The pipeline advances unless a finished result is still waiting.
    assign adv          = !out_valid || results.ready;
    assign accept       = pixels.valid && adv;
    assign pixels.ready = adv;

    imgc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .accept   (accept),
        .pixel    (pixels.pixel),
        .last_col (last_col),
        .last_row (last_row),
        .win      (win),
        .ctl      (ctl),
        .col      (win_col)
    );

    imgc_mac #(
        .PIXEL_BITS (PIXEL_BITS),
        .COEF_BITS  (COEF_BITS),
        .COL_W      (COL_W)
    ) u_mac (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .win          (win),
        .coef         (coef),
        .ctl_in       (ctl),
        .col_in       (win_col),
        .valid        (out_valid),
        .weighted_sum (results.weighted_sum),
        .centre_row   (results.centre_row),
        .centre_col   (results.centre_col)
    );

    assign results.valid = out_valid;

    // A window centre never lies on the zero border's first row or column.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (results.centre_row != '0) && (results.centre_col != '0))
        else $error("result centre on first row or column");

    // A waiting result must block new pixels.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !results.ready) |-> !pixels.ready)
        else $error("pixel accepted while result stalled");

    // Clamped frame size always leaves a full window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(last_col) >= 2) && (32'(last_col) < MAX_WIDTH) && (last_row >= ROW_W'(2)))
        else $error("clamped frame size out of range");
endmodule

/* test/image_correlate_3x3_checker.sv */
// Checker for the 3x3 image correlator: watches the configuration port and both
// stream channels, predicts every window sum and compares it with the results.
// Depends on imgc_pkg and the stream interfaces in imgc_if.
module image_correlate_3x3_checker
    import imgc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    imgc_pixel_if                 pixels,
    imgc_result_if                results,
    output int                    failures,
    output int                    pending,
    output bit                    frame_start,
    output int                    width_in_use
);

    localparam int LINE_LEN = MAX_WIDTH_DEF;
    localparam int PIX_W    = PIXEL_BITS_DEF;
    localparam int COEF_W   = COEF_BITS_DEF;
    localparam int COL_W    = $clog2(MAX_WIDTH_DEF);

    typedef struct packed {
        logic signed [SUM_W-1:0] weighted_sum;
        logic [ROW_W-1:0]        centre_row;
        logic [COL_W-1:0]        centre_col;
    } window_result_t;

    logic [FW_W-1:0]   width_reg;
    logic [ROW_W-1:0]  height_reg;
    logic [MASK_W-1:0] mask_rows [3];

    logic [PIX_W-1:0]  line_upper [LINE_LEN];
    logic [PIX_W-1:0]  line_lower [LINE_LEN];
    logic [PIX_W-1:0]  window [3][3];
    logic [COL_W-1:0]  col_pos;
    logic [ROW_W-1:0]  row_pos;

    window_result_t    awaited_windows [$];

    function automatic int clamp_width(logic [FW_W-1:0] raw);
        if (raw < 3) return 3;
        if (raw > LINE_LEN) return LINE_LEN;
        return int'(raw);
    endfunction

    function automatic int mask_coef(int r, int c);
        return int'(signed'(mask_rows[r][c*COEF_W +: COEF_W]));
    endfunction

    assign width_in_use = clamp_width(width_reg);
    assign frame_start  = (col_pos == '0) && (row_pos == '0);

    // Shifts one pixel through the line stores and the window, queues the
    // window sum when the window is complete, then advances the raster position.
    task automatic shift_pixel_in(input logic [PIX_W-1:0] px);
        int w;
        int h;
        int total;
        logic [PIX_W-1:0] upper_px;
        logic [PIX_W-1:0] lower_px;
        window_result_t sum_item;
        w = clamp_width(width_reg);
        h = (height_reg < 3) ? 3 : int'(height_reg);
        upper_px = line_upper[col_pos];
        lower_px = line_lower[col_pos];
        line_upper[col_pos] = lower_px;
        line_lower[col_pos] = px;
        for (int k = 0; k < 3; k++)
        begin
            window[k][0] = window[k][1];
            window[k][1] = window[k][2];
        end
        window[0][2] = upper_px;
        window[1][2] = lower_px;
        window[2][2] = px;

        if (row_pos >= 2 && col_pos >= 2)
        begin
            total = 0;
            for (int k = 0; k < 3; k++)
                for (int l = 0; l < 3; l++)
                    total += int'(window[k][l]) * mask_coef(k, l);
            sum_item.weighted_sum = total[SUM_W-1:0];
            sum_item.centre_row   = row_pos - 1'b1;
            sum_item.centre_col   = col_pos - 1'b1;
            awaited_windows.push_back(sum_item);
        end

        if (int'(col_pos) >= w - 1)
        begin
            col_pos = '0;
            if (int'(row_pos) >= h - 1)
                row_pos = '0;
            else
                row_pos = row_pos + 1'b1;
        end
        else
        begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic check_result();
        window_result_t want;
        if (awaited_windows.size() == 0)
        begin
            $error("result with no window waiting: weighted_sum %0d row %0d col %0d",
                   results.weighted_sum, results.centre_row, results.centre_col);
            failures++;
        end
        else
        begin
            want = awaited_windows.pop_front();
            if (results.weighted_sum !== want.weighted_sum)
            begin
                $error("weighted_sum: expected %0d, actual %0d",
                       want.weighted_sum, results.weighted_sum);
                failures++;
            end
            if (results.centre_row !== want.centre_row)
            begin
                $error("centre_row: expected %0d, actual %0d",
                       want.centre_row, results.centre_row);
                failures++;
            end
            if (results.centre_col !== want.centre_col)
            begin
                $error("centre_col: expected %0d, actual %0d",
                       want.centre_col, results.centre_col);
                failures++;
            end
        end
    endtask

    initial failures = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = FW_W'(3);
            height_reg = ROW_W'(3);
            for (int k = 0; k < 3; k++)
            begin
                mask_rows[k] = '0;
                for (int l = 0; l < 3; l++)
                    window[k][l] = '0;
            end
            for (int i = 0; i < LINE_LEN; i++)
            begin
                line_upper[i] = '0;
                line_lower[i] = '0;
            end
            col_pos = '0;
            row_pos = '0;
            awaited_windows.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg    = cfg_data[FW_W-1:0];
                    REG_FRAME_HEIGHT: height_reg   = cfg_data[ROW_W-1:0];
                    REG_MASK_TOP:     mask_rows[0] = cfg_data[MASK_W-1:0];
                    REG_MASK_MIDDLE:  mask_rows[1] = cfg_data[MASK_W-1:0];
                    REG_MASK_BOTTOM:  mask_rows[2] = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            // A result can never stem from a pixel taken at the same edge.
            if (results.valid && results.ready)
                check_result();
            if (pixels.valid && pixels.ready)
                shift_pixel_in(pixels.pixel);
        end
        pending = awaited_windows.size();
    end

endmodule

/* test/image_correlate_3x3_tb.sv */
// Top of the 3x3 image correlator testbench: clock, reset, configuration and
// pixel stimulus, result back-pressure, watchdog and verdict.
// Depends on imgc_pkg, imgc_if, the block itself and image_correlate_3x3_checker.
module image_correlate_3x3_tb;
    import imgc_pkg::*;

    // Register indexes past the last defined register; writes there must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LOW = 3'd5;

    // Cycles to let pass after the last expected result before touching the
    // configuration: the block keeps edge pixels in its five-stage pipeline even
    // when they produce no result, so a margin over that latency is kept.
    localparam int DRAIN_CYCLES = 10;

    // The longest correct stretch without any transaction is a configuration
    // pause plus drain plus the longest stall.
    localparam int QUIET_LIMIT = 1000;

    localparam int RANDOM_PIXELS = 780;

    // Length of the burst at the clamped largest width.
    localparam int FULL_RATE_PIXELS = 40;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // When set, neither side inserts idle cycles.
    bit steady;

    int mismatch_count;
    int pending_results;
    bit frame_start;
    int width_in_use;
    int quiet_cycles;

    imgc_pixel_if  pixels_ch ();
    imgc_result_if results_ch ();

    image_correlate_3x3 uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pixels    (pixels_ch),
        .results   (results_ch)
    );

    image_correlate_3x3_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixels       (pixels_ch),
        .results      (results_ch),
        .failures     (mismatch_count),
        .pending      (pending_results),
        .frame_start  (frame_start),
        .width_in_use (width_in_use)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any transaction on either channel restarts the count. Values are
    // read right at the rising edge, so they are the ones the block sampled.
    initial quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pixels_ch.valid && pixels_ch.ready) ||
                (results_ch.valid && results_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= QUIET_LIMIT)
            begin
                $error("no transaction for %0d cycles", QUIET_LIMIT);
                $display("Verification failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // All inputs change at the falling edge, away from the rising edge at which
    // the block samples them.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // Offers one pixel after a random idle gap and returns at the rising edge
    // where the transaction took place. Valid stays high on return, so a
    // following pixel with no gap goes out back to back; each falling edge sees
    // at most one assignment to valid.
    task automatic send_pixel(input logic [PIXEL_BITS_DEF-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 11);
        repeat (gap)
        begin
            @(negedge clk);
            pixels_ch.valid <= 1'b0;
        end
        @(negedge clk);
        pixels_ch.valid <= 1'b1;
        pixels_ch.pixel <= value;
        do
            @(posedge clk);
        while (!pixels_ch.ready);
    endtask

    // Stops the pixel stream and waits until every predicted result has come
    // out, then lets the pipeline empty of the pixels that produce nothing.
    // Pending is read at falling edges, where the checker never updates it.
    task automatic settle();
        @(negedge clk);
        pixels_ch.valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Pixel values lean toward the two extremes now and then.
    function automatic logic [PIXEL_BITS_DEF-1:0] pick_pixel();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return PIXEL_BITS_DEF'($urandom);
        endcase
    endfunction

    // Mask rows: all most negative, all most positive, all zero, or random.
    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 5))
            0: return 24'h808080;
            1: return 24'h7F7F7F;
            2: return '0;
            default: return MASK_W'($urandom);
        endcase
    endfunction

    // Widths are mostly small so that frames finish quickly; now and then a
    // value at or past the largest width, which the block clamps to it. Bits
    // above the register width carry noise that must be dropped.
    function automatic logic [CFG_DATA_W-1:0] pick_width();
        logic [FW_W-1:0] raw;
        if ($urandom_range(0, 11) == 0)
            raw = FW_W'($urandom_range(MAX_WIDTH_DEF, (1 << FW_W) - 1));
        else
            raw = FW_W'($urandom_range(0, 14));
        return {(CFG_DATA_W - FW_W)'($urandom), raw};
    endfunction

    // Heights: mostly small (below three is clamped up), sometimes the
    // largest one or any 16-bit value.
    function automatic logic [CFG_DATA_W-1:0] pick_height();
        logic [ROW_W-1:0] raw;
        case ($urandom_range(0, 7))
            0: raw = '1;
            1: raw = ROW_W'($urandom);
            default: raw = ROW_W'($urandom_range(0, 9));
        endcase
        return {(CFG_DATA_W - ROW_W)'($urandom), raw};
    endfunction

    // The result sink draws an idle gap for every transaction, then holds
    // ready high until a result is taken.
    initial
    begin : result_sink
        int gap;
        results_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = steady ? 0 : $urandom_range(0, 11);
            repeat (gap)
            begin
                @(negedge clk);
                results_ch.ready <= 1'b0;
            end
            @(negedge clk);
            results_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!results_ch.valid);
        end
    end

    initial
    begin : stimulus
        int random_count;
        int burst_len;
        int narrow_max;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pixels_ch.valid = 1'b0;
        pixels_ch.pixel = '0;
        steady          = 1'b0;
        rst_n           = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A 3x3 frame of full-scale pixels under an all most
        // negative mask gives the smallest possible sum, then under an all
        // most positive mask the largest one.
        write_reg(REG_FRAME_WIDTH, 24'd3);
        write_reg(REG_FRAME_HEIGHT, 24'd3);
        write_reg(REG_MASK_TOP, 24'h808080);
        write_reg(REG_MASK_MIDDLE, 24'h808080);
        write_reg(REG_MASK_BOTTOM, 24'h808080);
        repeat (9) send_pixel('1);
        settle();

        write_reg(REG_MASK_TOP, 24'h7F7F7F);
        write_reg(REG_MASK_MIDDLE, 24'h7F7F7F);
        write_reg(REG_MASK_BOTTOM, 24'h7F7F7F);
        repeat (9) send_pixel('1);
        settle();

        // Sizes below the legal range fall back to three, a write to an index
        // with no register behind it changes nothing, and a mask with a
        // different coefficient at every tap shows the window orientation
        // against a ramp of pixels starting at zero.
        write_reg(REG_FRAME_WIDTH, 24'd0);
        write_reg(REG_FRAME_HEIGHT, 24'd1);
        write_reg(REG_MASK_TOP, 24'hFE0201);
        write_reg(REG_MASK_MIDDLE, 24'h0504FD);
        write_reg(REG_MASK_BOTTOM, 24'h807F00);
        write_reg(REG_UNUSED_LOW, 24'hFFFFFF);
        for (int i = 0; i < 9; i++)
            send_pixel(PIXEL_BITS_DEF'(i * 31));
        settle();

        // The largest width, written as an out of range value that clamps to
        // it, with a height that clamps up to three. A burst with no idling at
        // all gives a long stretch at full rate on the first row; the random
        // part then narrows the width in the middle of this frame.
        write_reg(REG_FRAME_WIDTH, {13'h1ABC, 11'h7FF});
        write_reg(REG_FRAME_HEIGHT, 24'd2);
        write_reg(REG_MASK_TOP, pick_mask());
        steady = 1'b1;
        @(negedge clk);
        repeat (FULL_RATE_PIXELS) send_pixel(pick_pixel());
        settle();
        steady = 1'b0;

        // Random part: bursts of pixels, each after a pause in which some
        // registers change. The width may grow only at the start of a frame, so
        // that no line store entry is read before it has been written; in the
        // middle of a frame it may only shrink, which wraps the column counter
        // when it already stands past the new last column. Heights change at any
        // point, which can end the current frame early. Small sizes keep most
        // pixels inside full windows.
        random_count = 0;
        while (random_count < RANDOM_PIXELS)
        begin
            settle();
            steady = ($urandom_range(0, 7) == 0);

            if (frame_start)
            begin
                if ($urandom_range(0, 1) == 1)
                    write_reg(REG_FRAME_WIDTH, pick_width());
            end
            else if (width_in_use > 64 || $urandom_range(0, 5) == 0)
            begin
                narrow_max = (width_in_use > 64) ? 12 : width_in_use;
                write_reg(REG_FRAME_WIDTH,
                          {(CFG_DATA_W - FW_W)'($urandom),
                           FW_W'($urandom_range(0, narrow_max))});
            end

            if ($urandom_range(0, 2) == 0)
                write_reg(REG_FRAME_HEIGHT, pick_height());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_MASK_TOP, pick_mask());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_MASK_MIDDLE, pick_mask());
            if ($urandom_range(0, 2) == 0)
                write_reg(REG_MASK_BOTTOM, pick_mask());
            if ($urandom_range(0, 19) == 0)
                write_reg(REG_UNUSED_LOW + CFG_IDX_W'($urandom_range(0, 2)),
                          CFG_DATA_W'($urandom));

            burst_len = $urandom_range(4, 80);
            repeat (burst_len) send_pixel(pick_pixel());
            random_count += burst_len;
        end

        settle();
        if (mismatch_count == 0 && pending_results == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
